// File: rtl/core/bptc_pkg.sv
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types and constants of the barometer compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bptc_pkg;

	localparam int unsigned DivW   = 32;
	localparam int unsigned CfgIdxW = 8;
	localparam int unsigned CfgW   = 32;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_AC1   = 8'd0,
		REG_AC2   = 8'd1,
		REG_AC3   = 8'd2,
		REG_AC4   = 8'd3,
		REG_AC5   = 8'd4,
		REG_AC6   = 8'd5,
		REG_B1_B2 = 8'd6,
		REG_MC_MD = 8'd7
	} reg_idx_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	// calibration reset values
	localparam logic [15:0] RstAc1  = 16'd408;
	localparam logic [15:0] RstAc2  = 16'hFFB8;
	localparam logic [15:0] RstAc3  = 16'hC7D1;
	localparam logic [15:0] RstAc4  = 16'd32741;
	localparam logic [15:0] RstAc5  = 16'd32757;
	localparam logic [15:0] RstAc6  = 16'd23153;
	localparam logic [31:0] RstB1B2 = 32'd405667844;
	localparam logic [31:0] RstMcMd = 32'd3724086068;

	// arithmetic constants
	localparam logic signed [31:0] B6Offset  = 32'sd4000;
	localparam logic [31:0]        PScale    = 32'd50000;
	localparam logic signed [31:0] CoefX1    = 32'sd3038;
	localparam logic signed [31:0] CoefX2    = -32'sd7357;
	localparam logic signed [31:0] CoefOff   = 32'sd3791;
	localparam logic signed [31:0] B4Offset  = 32'sd32768;
	localparam logic signed [31:0] TempMax   = 32'sd32767;
	localparam logic signed [31:0] TempMin   = -32'sd32768;
	localparam logic signed [31:0] PressMax  = 32'sd131071;

	typedef struct packed {
		logic [15:0] raw_temp;
		logic [15:0] raw_pressure;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] temp_tenths;
		logic [16:0]        pressure_pa;
		logic [1:0]         status;
	} out_item_t;

	// data riding along the temperature divider
	typedef struct packed {
		logic               err;
		logic               neg;
		logic signed [31:0] x1;
		logic [15:0]        up;
	} side_t_div_t;

	// data riding along the pressure divider
	typedef struct packed {
		logic               err;
		logic               post;
		logic signed [31:0] t;
	} side_p_div_t;

endpackage

`default_nettype wire

// File: rtl/core/baro_pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Fixed-point barometer temperature and pressure compensation pipeline.
// ----------------------------------------------------------------------------
// Takes one raw temperature/pressure item per cycle and returns temperature in
// tenths of a degree and pressure in pascals, with status for zero divisors
// and saturation. From acceptance to the result register an item passes
// two 32-stage divider pipelines (one per division) and 13 arithmetic stages.
// Throughput is one item per cycle; the whole pipeline freezes while a result
// waits at the output. Calibration writes are taken at any time but must only
// occur while the pipeline is empty.
`default_nettype none

module baro_pressure_temp_compensation (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire bptc_pkg::in_item_t            in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output bptc_pkg::out_item_t                out_data,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bptc_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [bptc_pkg::CfgW-1:0]     cfg_data
);

	// calibration registers
	logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q, ac5_q, ac6_q;
	logic [31:0] b1b2_q, mcmd_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac1_q  <= bptc_pkg::RstAc1;
			ac2_q  <= bptc_pkg::RstAc2;
			ac3_q  <= bptc_pkg::RstAc3;
			ac4_q  <= bptc_pkg::RstAc4;
			ac5_q  <= bptc_pkg::RstAc5;
			ac6_q  <= bptc_pkg::RstAc6;
			b1b2_q <= bptc_pkg::RstB1B2;
			mcmd_q <= bptc_pkg::RstMcMd;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bptc_pkg::REG_AC1:   ac1_q  <= cfg_data[15:0];
				bptc_pkg::REG_AC2:   ac2_q  <= cfg_data[15:0];
				bptc_pkg::REG_AC3:   ac3_q  <= cfg_data[15:0];
				bptc_pkg::REG_AC4:   ac4_q  <= cfg_data[15:0];
				bptc_pkg::REG_AC5:   ac5_q  <= cfg_data[15:0];
				bptc_pkg::REG_AC6:   ac6_q  <= cfg_data[15:0];
				bptc_pkg::REG_B1_B2: b1b2_q <= cfg_data;
				bptc_pkg::REG_MC_MD: mcmd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sign-extended coefficients (ac4, ac5 and ac6 are zero-extended)
	logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [31:0]        ac4, ac5, ac6;
	assign ac1 = {{16{ac1_q[15]}}, ac1_q};
	assign ac2 = {{16{ac2_q[15]}}, ac2_q};
	assign ac3 = {{16{ac3_q[15]}}, ac3_q};
	assign ac4 = {16'd0, ac4_q};
	assign ac5 = {16'd0, ac5_q};
	assign ac6 = {16'd0, ac6_q};
	assign b1  = {{16{b1b2_q[31]}}, b1b2_q[31:16]};
	assign b2  = {{16{b1b2_q[15]}}, b1b2_q[15:0]};
	assign mc  = {{16{mcmd_q[31]}}, mcmd_q[31:16]};
	assign md  = {{16{mcmd_q[15]}}, mcmd_q[15:0]};

	// global advance: everything moves unless a result is stuck
	logic en;
	logic out_valid_q;
	bptc_pkg::out_item_t out_q;
	assign en       = ~out_valid_q | out_ready;
	assign in_ready = en;

	// S1: uncompensated temperature term
	logic               v_s1;
	logic signed [31:0] x1_s1;
	logic [15:0]        up_s1;
	logic signed [31:0] dt;
	logic signed [31:0] dtm;
	always_comb begin
		dt  = signed'({16'd0, in_data.raw_temp}) - signed'(ac6);
		dtm = dt * signed'(ac5);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= dtm >>> 15;
			up_s1 <= in_data.raw_pressure;
		end
	end

	// S2: operands of the signed temperature division as magnitudes
	logic                     v_s2;
	logic [31:0]              num_s2, den_s2;
	bptc_pkg::side_t_div_t    sd1_s2;
	logic signed [31:0]       den_c, num_c;
	always_comb begin
		den_c = x1_s1 + md;
		num_c = {mc[20:0], 11'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2     <= num_c[31] ? 32'(-num_c) : num_c;
			den_s2     <= den_c[31] ? 32'(-den_c) : den_c;
			sd1_s2.err <= (den_c == 32'sd0);
			sd1_s2.neg <= num_c[31] ^ den_c[31];
			sd1_s2.x1  <= x1_s1;
			sd1_s2.up  <= up_s1;
		end
	end

	logic                  v_d1;
	logic [31:0]           q_d1;
	logic [$bits(bptc_pkg::side_t_div_t)-1:0] sdr_d1;
	bptc_pkg::side_t_div_t sd1_d1;

	bptc_div #(
		.W      (bptc_pkg::DivW),
		.SIDE_W ($bits(bptc_pkg::side_t_div_t))
	) u_div_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.dividend  (num_s2),
		.divisor   (den_s2),
		.side_in   (sd1_s2),
		.out_valid (v_d1),
		.quotient  (q_d1),
		.side_out  (sdr_d1)
	);
	assign sd1_d1 = bptc_pkg::side_t_div_t'(sdr_d1);

	// S3: b5, temperature, b6
	logic               v_s3, err_s3;
	logic signed [31:0] t_s3, b6_s3;
	logic [15:0]        up_s3;
	logic signed [31:0] x2_c, b5_c, t8_c;
	always_comb begin
		x2_c = sd1_d1.neg ? 32'(-signed'(q_d1)) : signed'(q_d1);
		b5_c = sd1_d1.x1 + x2_c;
		t8_c = b5_c + 32'sd8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s3 <= sd1_d1.err;
			t_s3   <= t8_c >>> 4;
			b6_s3  <= b5_c - bptc_pkg::B6Offset;
			up_s3  <= sd1_d1.up;
		end
	end

	// S4: square of b6 and linear b6 terms
	logic               v_s4, err_s4;
	logic signed [31:0] t_s4, sq_s4, x2a_s4, x1c_s4;
	logic [15:0]        up_s4;
	logic signed [31:0] sqm, a2m, a3m;
	always_comb begin
		sqm = b6_s3 * b6_s3;
		a2m = ac2 * b6_s3;
		a3m = ac3 * b6_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s4 <= err_s3;
			t_s4   <= t_s3;
			sq_s4  <= sqm >>> 12;
			x2a_s4 <= a2m >>> 11;
			x1c_s4 <= a3m >>> 13;
			up_s4  <= up_s3;
		end
	end

	// S5: square terms
	logic               v_s5, err_s5;
	logic signed [31:0] t_s5, x1a_s5, x2a_s5, x1c_s5, x2b_s5;
	logic [15:0]        up_s5;
	logic signed [31:0] b2m, b1m;
	always_comb begin
		b2m = b2 * sq_s4;
		b1m = b1 * sq_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s5 <= err_s4;
			t_s5   <= t_s4;
			x1a_s5 <= b2m >>> 11;
			x2a_s5 <= x2a_s4;
			x1c_s5 <= x1c_s4;
			x2b_s5 <= b1m >>> 16;
			up_s5  <= up_s4;
		end
	end

	// S6: b3 numerator and b4 correction
	logic               v_s6, err_s6;
	logic signed [31:0] t_s6, b3n_s6, x3p_s6;
	logic [15:0]        up_s6;
	logic signed [31:0] x3c;
	always_comb begin
		x3c = x1c_s5 + x2b_s5 + 32'sd2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s6 <= err_s5;
			t_s6   <= t_s5;
			b3n_s6 <= {ac1[29:0], 2'd0} + x1a_s5 + x2a_s5 + 32'sd2;
			x3p_s6 <= x3c >>> 2;
			up_s6  <= up_s5;
		end
	end

	// S7: b3 (truncating divide by four) and b4
	logic               v_s7, err_s7;
	logic signed [31:0] t_s7, b3_s7;
	logic [16:0]        b4_s7;
	logic [15:0]        up_s7;
	logic signed [31:0] b3r;
	logic [31:0]        b4m;
	always_comb begin
		b3r = b3n_s6[31] ? (b3n_s6 + 32'sd3) : b3n_s6;
		b4m = ac4 * 32'(x3p_s6 + bptc_pkg::B4Offset);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s7 <= err_s6;
			t_s7   <= t_s6;
			b3_s7  <= b3r >>> 2;
			b4_s7  <= b4m[31:15];
			up_s7  <= up_s6;
		end
	end

	// S8: b7
	logic               v_s8, err_s8;
	logic signed [31:0] t_s8;
	logic [16:0]        b4_s8;
	logic [31:0]        b7_s8;
	logic [31:0]        up32;
	always_comb begin
		up32 = {16'd0, up_s7} - 32'(b3_s7);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s8 <= err_s7 | (b4_s7 == 17'd0);
			t_s8   <= t_s7;
			b4_s8  <= b4_s7;
			b7_s8  <= up32 * bptc_pkg::PScale;
		end
	end

	// S9: pressure division operands
	logic                  v_s9;
	logic [31:0]           dnd_s9, dvs_s9;
	bptc_pkg::side_p_div_t sd2_s9;
	always_ff @(posedge clk) begin
		if (en) begin
			dnd_s9      <= b7_s8[31] ? b7_s8 : {b7_s8[30:0], 1'b0};
			dvs_s9      <= {15'd0, b4_s8};
			sd2_s9.err  <= err_s8;
			sd2_s9.post <= b7_s8[31];
			sd2_s9.t    <= t_s8;
		end
	end

	logic                  v_d2;
	logic [31:0]           q_d2;
	logic [$bits(bptc_pkg::side_p_div_t)-1:0] sdr_d2;
	bptc_pkg::side_p_div_t sd2_d2;

	bptc_div #(
		.W      (bptc_pkg::DivW),
		.SIDE_W ($bits(bptc_pkg::side_p_div_t))
	) u_div_p (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s9),
		.dividend  (dnd_s9),
		.divisor   (dvs_s9),
		.side_in   (sd2_s9),
		.out_valid (v_d2),
		.quotient  (q_d2),
		.side_out  (sdr_d2)
	);
	assign sd2_d2 = bptc_pkg::side_p_div_t'(sdr_d2);

	// S10: raw pressure and correction products
	logic               v_s10, err_s10;
	logic signed [31:0] t_s10, p_s10, x1_s10, x2_s10;
	logic signed [31:0] p_c, pa_c, pam, p7m;
	always_comb begin
		p_c  = sd2_d2.post ? signed'({q_d2[30:0], 1'b0}) : signed'(q_d2);
		pa_c = p_c >>> 8;
		pam  = pa_c * pa_c;
		p7m  = bptc_pkg::CoefX2 * p_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s10 <= sd2_d2.err;
			t_s10   <= sd2_d2.t;
			p_s10   <= p_c;
			x1_s10  <= pam;
			x2_s10  <= p7m >>> 16;
		end
	end

	// S11: scale the square term
	logic               v_s11, err_s11;
	logic signed [31:0] t_s11, p_s11, x1_s11, x2_s11;
	logic signed [31:0] x1m;
	assign x1m = x1_s10 * bptc_pkg::CoefX1;

	always_ff @(posedge clk) begin
		if (en) begin
			err_s11 <= err_s10;
			t_s11   <= t_s10;
			p_s11   <= p_s10;
			x1_s11  <= x1m >>> 16;
			x2_s11  <= x2_s10;
		end
	end

	// S12: final pressure
	logic               v_s12, err_s12;
	logic signed [31:0] t_s12, p_s12;
	logic signed [31:0] corr;
	assign corr = x1_s11 + x2_s11 + bptc_pkg::CoefOff;

	always_ff @(posedge clk) begin
		if (en) begin
			err_s12 <= err_s11;
			t_s12   <= t_s11;
			p_s12   <= p_s11 + (corr >>> 4);
		end
	end

	// S13: saturation, status and output register
	bptc_pkg::out_item_t res_c;
	logic t_hi, t_lo, p_hi, p_lo;
	always_comb begin
		t_hi = t_s12 > bptc_pkg::TempMax;
		t_lo = t_s12 < bptc_pkg::TempMin;
		p_hi = p_s12 > bptc_pkg::PressMax;
		p_lo = p_s12[31];
		res_c.temp_tenths = t_hi ? 16'sh7FFF : (t_lo ? 16'sh8000 : t_s12[15:0]);
		res_c.pressure_pa = p_hi ? 17'h1FFFF : (p_lo ? 17'd0 : p_s12[16:0]);
		res_c.status      = (t_hi | t_lo | p_hi | p_lo) ? bptc_pkg::ST_SAT
		                                                : bptc_pkg::ST_OK;
		if (err_s12) begin
			res_c.temp_tenths = '0;
			res_c.pressure_pa = '0;
			res_c.status      = bptc_pkg::ST_DIV0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= res_c;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			v_s10       <= 1'b0;
			v_s11       <= 1'b0;
			v_s12       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_d1;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			v_s9        <= v_s8;
			v_s10       <= v_d2;
			v_s11       <= v_s10;
			v_s12       <= v_s11;
			out_valid_q <= v_s12;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == bptc_pkg::ST_DIV0
		|-> out_data.temp_tenths == 16'sd0 && out_data.pressure_pa == 17'd0)
		else $error("zero-divisor result with nonzero fields");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3)
		else $error("undefined status code");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(v_s12) && $stable(v_d2))
		else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// File: rtl/core/bptc_div.sv
// ----------------------------------------------------------------------------
// bptc_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// sideband word that travels alongside each item.
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_div #(
	parameter int unsigned W      = bptc_pkg::DivW,
	parameter int unsigned SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [W-1:0]      dividend,
	input  wire logic [W-1:0]      divisor,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_valid,
	output logic [W-1:0]           quotient,
	output logic [SIDE_W-1:0]      side_out
);

	logic              vld_s  [W];
	logic [W-1:0]      rem_s  [W];
	logic [W-1:0]      dq_s   [W];
	logic [W-1:0]      dvs_s  [W];
	logic [SIDE_W-1:0] side_s [W];

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic              pv;
		logic [W-1:0]      prem;
		logic [W-1:0]      pdq;
		logic [W-1:0]      pdvs;
		logic [SIDE_W-1:0] pside;
		logic [W:0]        trial;
		logic [W:0]        diff;
		logic              ge;

		if (i == 0) begin : g_first
			assign pv    = in_valid;
			assign prem  = '0;
			assign pdq   = dividend;
			assign pdvs  = divisor;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = vld_s[i-1];
			assign prem  = rem_s[i-1];
			assign pdq   = dq_s[i-1];
			assign pdvs  = dvs_s[i-1];
			assign pside = side_s[i-1];
		end

		// shift in next dividend bit, subtract if it fits
		always_comb begin
			trial = {prem, pdq[W-1]};
			diff  = trial - {1'b0, pdvs};
			ge    = ~diff[W];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? diff[W-1:0] : trial[W-1:0];
				dq_s[i]   <= {pdq[W-2:0], ge};
				dvs_s[i]  <= pdvs;
				side_s[i] <= pside;
			end
		end
	end

	assign out_valid = vld_s[W-1];
	assign quotient  = dq_s[W-1];
	assign side_out  = side_s[W-1];

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the barometer compensation pipeline: a directed
// table of raw readings under several calibration sets, then random readings,
// each result compared field by field with a behavioral predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bptc_pkg::*;

	localparam int Latency   = 80;
	localparam int CycleLimit = 400000;
	localparam int NumRandom = 1750;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0] cfg_data = '0;

	baro_pressure_temp_compensation uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// calibration copy
	logic [15:0] cal_ac1, cal_ac2, cal_ac3, cal_ac4, cal_ac5, cal_ac6;
	logic [31:0] cal_b1b2, cal_mcmd;

	out_item_t expected_q[$];
	int errors = 0;
	int checked = 0;
	int n_div0 = 0;
	int n_sat = 0;
	int cycles = 0;
	int gap_pct = 13;

	// directed rows: readings plus an optional typed-in answer
	typedef struct {
		logic [15:0] ut;
		logic [15:0] up;
		logic        has_exp;
		out_item_t   exp;
	} vec_t;

	function automatic logic signed [31:0] asr(logic signed [31:0] x, int n);
		return x >>> n;
	endfunction

	function automatic logic signed [31:0] sdiv(logic signed [31:0] a, logic signed [31:0] b);
		if (a == 32'sh8000_0000 && b == -32'sd1)
			return a;
		return a / b;
	endfunction

	// fixed-point compensation of one reading pair
	function automatic out_item_t compensate(logic [15:0] ut_raw, logic [15:0] up_raw);
		logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
		logic signed [31:0] ut, x1, x2, x3, b3, b5, b6, sq, t, p, den;
		logic [31:0] ac4, b4, b7, up32;
		logic [63:0] prod;
		out_item_t r;
		ac1 = 32'(signed'(cal_ac1));
		ac2 = 32'(signed'(cal_ac2));
		ac3 = 32'(signed'(cal_ac3));
		ac4 = {16'd0, cal_ac4};
		ac5 = {16'd0, cal_ac5};
		ac6 = {16'd0, cal_ac6};
		b1 = 32'(signed'(cal_b1b2[31:16]));
		b2 = 32'(signed'(cal_b1b2[15:0]));
		mc = 32'(signed'(cal_mcmd[31:16]));
		md = 32'(signed'(cal_mcmd[15:0]));
		ut = {16'd0, ut_raw};
		r = '0;
		r.status = ST_DIV0;
		x1 = asr((ut - ac6) * ac5, 15);
		den = x1 + md;
		if (den == 0)
			return r;
		x2 = sdiv(mc * 32'sd2048, den);
		b5 = x1 + x2;
		t = asr(b5 + 8, 4);
		b6 = b5 - B6Offset;
		sq = asr(b6 * b6, 12);
		x1 = asr(b2 * sq, 11);
		x2 = asr(ac2 * b6, 11);
		x3 = x1 + x2;
		b3 = sdiv(ac1 * 4 + x3 + 2, 4);
		x1 = asr(ac3 * b6, 13);
		x2 = asr(b1 * sq, 16);
		x3 = asr(x1 + x2 + 2, 2);
		prod = 64'(ac4) * 64'(32'(x3 + B4Offset));
		b4 = prod[31:0] >> 15;
		if (b4 == 0)
			return r;
		up32 = {16'd0, up_raw} - b3;
		b7 = up32 * PScale;
		if (!b7[31])
			p = (b7 * 2) / b4;
		else
			p = (b7 / b4) * 2;
		x1 = asr(p, 8) * asr(p, 8);
		x1 = asr(x1 * CoefX1, 16);
		x2 = asr(CoefX2 * p, 16);
		p = p + asr(x1 + x2 + CoefOff, 4);
		r.status = ST_OK;
		if (t > TempMax) begin t = TempMax; r.status = ST_SAT; end
		if (t < TempMin) begin t = TempMin; r.status = ST_SAT; end
		if (p > PressMax) begin p = PressMax; r.status = ST_SAT; end
		if (p < 0) begin p = 0; r.status = ST_SAT; end
		r.temp_tenths = t[15:0];
		r.pressure_pa = p[16:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("error @%0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// output side: random stall, check at rising edge
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= gap_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected item, queue size", 1, 0);
			end else begin
				out_item_t e;
				e = expected_q.pop_front();
				checked++;
				if (e.status == ST_DIV0) n_div0++;
				if (e.status == ST_SAT) n_sat++;
				if (out_data.temp_tenths !== e.temp_tenths)
					report_mismatch("temp_tenths", out_data.temp_tenths, e.temp_tenths);
				if (out_data.pressure_pa !== e.pressure_pa)
					report_mismatch("pressure_pa", out_data.pressure_pa, e.pressure_pa);
				if (out_data.status !== e.status)
					report_mismatch("status", out_data.status, e.status);
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_AC1: cal_ac1 = val[15:0];
			REG_AC2: cal_ac2 = val[15:0];
			REG_AC3: cal_ac3 = val[15:0];
			REG_AC4: cal_ac4 = val[15:0];
			REG_AC5: cal_ac5 = val[15:0];
			REG_AC6: cal_ac6 = val[15:0];
			REG_B1_B2: cal_b1b2 = val;
			default: cal_mcmd = val;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// send one reading pair; a gap drops valid only between items
	task automatic send_item(logic [15:0] ut, logic [15:0] up, logic has_exp, out_item_t exp);
		out_item_t pred;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		pred = compensate(ut, up);
		if (has_exp && pred !== exp) begin
			report_mismatch("table row temp_tenths", pred.temp_tenths, exp.temp_tenths);
			report_mismatch("table row pressure_pa", pred.pressure_pa, exp.pressure_pa);
			report_mismatch("table row status", pred.status, exp.status);
		end
		in_valid <= 1'b1;
		in_data <= '{raw_temp: ut, raw_pressure: up};
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(has_exp ? exp : pred);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (Latency) @(negedge clk);
	endtask

	task automatic load_cal(logic [15:0] a1, a2, a3, a4, a5, a6, logic [31:0] bb, mm);
		write_reg(REG_AC1, {16'd0, a1});
		write_reg(REG_AC2, {16'd0, a2});
		write_reg(REG_AC3, {16'd0, a3});
		write_reg(REG_AC4, {16'd0, a4});
		write_reg(REG_AC5, {16'd0, a5});
		write_reg(REG_AC6, {16'd0, a6});
		write_reg(REG_B1_B2, bb);
		write_reg(REG_MC_MD, mm);
	endtask

	task automatic random_cal();
		load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), $urandom, $urandom);
	endtask

	vec_t dir_rows[$];
	out_item_t zero_div;
	out_item_t dummy;

	initial begin
		cal_ac1 = RstAc1; cal_ac2 = RstAc2; cal_ac3 = RstAc3;
		cal_ac4 = RstAc4; cal_ac5 = RstAc5; cal_ac6 = RstAc6;
		cal_b1b2 = RstB1B2; cal_mcmd = RstMcMd;
		zero_div = '{temp_tenths: 16'sd0, pressure_pa: 17'd0, status: ST_DIV0};
		dummy = '0;

		// directed rows under the reset calibration
		dir_rows.push_back('{16'd27898, 16'd23843, 1'b0, dummy});
		dir_rows.push_back('{16'd0, 16'd0, 1'b0, dummy});
		dir_rows.push_back('{16'hFFFF, 16'hFFFF, 1'b0, dummy});
		dir_rows.push_back('{16'd0, 16'hFFFF, 1'b0, dummy});
		dir_rows.push_back('{16'hFFFF, 16'd0, 1'b0, dummy});
		dir_rows.push_back('{16'h5555, 16'hAAAA, 1'b0, dummy});
		dir_rows.push_back('{16'hAAAA, 16'h5555, 1'b0, dummy});
		dir_rows.push_back('{16'd23153, 16'd30000, 1'b0, dummy});

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].ut, dir_rows[i].up, dir_rows[i].has_exp, dir_rows[i].exp);
		drain();

		// md=0 with ut==ac6 makes the temperature divisor zero
		load_cal(16'd408, 16'hFFB8, 16'hC7D1, 16'd32741, 16'd32757, 16'd23153,
			RstB1B2, 32'hDDF9_0000);
		send_item(16'd23153, 16'd1234, 1'b1, zero_div);
		send_item(16'd23153, 16'hFFFF, 1'b1, zero_div);
		drain();
		// ac4 of zero makes the pressure scale zero
		write_reg(REG_AC4, 32'd0);
		write_reg(REG_MC_MD, RstMcMd);
		send_item(16'd27898, 16'd23843, 1'b1, zero_div);
		send_item(16'hFFFF, 16'd0, 1'b1, zero_div);
		drain();

		// extreme calibration sets
		load_cal(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			32'h7FFF_7FFF, 32'h7FFF_7FFF);
		for (int k = 0; k < 4; k++)
			send_item(k[0] ? 16'hFFFF : 16'd0, k[1] ? 16'hFFFF : 16'd0, 1'b0, dummy);
		drain();
		load_cal(16'h8000, 16'h8000, 16'h8000, 16'd1, 16'd1, 16'd0,
			32'h8000_8000, 32'h8000_8000);
		for (int k = 0; k < 4; k++)
			send_item(k[0] ? 16'hFFFF : 16'd0, k[1] ? 16'hFFFF : 16'd0, 1'b0, dummy);
		drain();

		// random readings: some phases at or near the reset calibration, others with random sets
		for (int ph = 0; ph < 7; ph++) begin
			if (ph == 0)
				load_cal(RstAc1, RstAc2, RstAc3, RstAc4, RstAc5, RstAc6, RstB1B2, RstMcMd);
			else if (ph == 3)
				random_cal();
			else if (ph == 5)
				load_cal(RstAc1, RstAc2, RstAc3, RstAc4, RstAc5, RstAc6, RstB1B2,
					{RstMcMd[31:16], 16'($urandom_range(40))});
			else if (ph != 1)
				random_cal();
			gap_pct = (ph == 2) ? 0 : 13;
			for (int k = 0; k < NumRandom / 7; k++) begin
				logic [15:0] ut, up;
				ut = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(22000, 34000));
				up = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20000, 42000));
				send_item(ut, up, 1'b0, dummy);
				// hold off until the pipeline has fully drained
				if (k == 100 && ph == 1) begin
					in_valid <= 1'b0;
					while (expected_q.size() != 0)
						@(negedge clk);
				end
			end
			drain();
		end

		$display("checked %0d results, %0d zero-divisor, %0d saturated, over several calibrations",
			checked, n_div0, n_sat);
		if (errors == 0 && expected_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
